@@ rtl/clex_pkg.sv @@
// ----------------------------------------------------------------------------
// clex_pkg
// shared types and constants for the c-like token lexer core
// ----------------------------------------------------------------------------
package clex_pkg;

    localparam int IDENT_BUF_BYTES = 32;
    localparam int MAX_IDENT       = IDENT_BUF_BYTES - 1;
    localparam int CHUNK_BYTES     = 8;
    localparam int CHUNK_SHIFT     = $clog2(CHUNK_BYTES);
    localparam int NUM_ROWS        = IDENT_BUF_BYTES / CHUNK_BYTES;
    localparam int ROW_W           = $clog2(NUM_ROWS);
    localparam int COUNT_W         = $clog2(IDENT_BUF_BYTES);
    localparam int VALUE_W         = 64;
    localparam int KIND_W          = 4;
    localparam int TDATA_W         = 72;
    localparam int TUSER_W         = 5;

    localparam logic [KIND_W-1:0] KIND_IDENT = 4'd0;
    localparam logic [KIND_W-1:0] KIND_INT   = 4'd1;
    localparam logic [KIND_W-1:0] KIND_PUNCT = 4'd2;
    localparam logic [KIND_W-1:0] KIND_ARROW = 4'd3;
    localparam logic [KIND_W-1:0] KIND_EQ    = 4'd4;
    localparam logic [KIND_W-1:0] KIND_SHR   = 4'd5;
    localparam logic [KIND_W-1:0] KIND_SHL   = 4'd6;
    localparam logic [KIND_W-1:0] KIND_NE    = 4'd7;
    localparam logic [KIND_W-1:0] KIND_GE    = 4'd8;
    localparam logic [KIND_W-1:0] KIND_LE    = 4'd9;
    localparam logic [KIND_W-1:0] KIND_OR    = 4'd10;
    localparam logic [KIND_W-1:0] KIND_AND   = 4'd11;
    localparam logic [KIND_W-1:0] KIND_END   = 4'd12;

    // one result transaction
    typedef struct packed {
        logic [KIND_W-1:0]  kind;
        logic [VALUE_W-1:0] value;
        logic [COUNT_W-1:0] len;
        logic [ROW_W-1:0]   chunk;
        logic               flag;
        logic               last;
    } token_t;

    // byte write into the identifier buffer
    typedef struct packed {
        logic               en;
        logic [COUNT_W-1:0] addr;
        logic [7:0]         data;
    } ram_wr_t;

    // row read from the identifier buffer
    typedef struct packed {
        logic             en;
        logic [ROW_W-1:0] row;
    } ram_rd_t;

endpackage

@@ rtl/clex_ident_ram.sv @@
// ----------------------------------------------------------------------------
// clex_ident_ram
// identifier character buffer: byte writes, one 8-byte row read per cycle
// ----------------------------------------------------------------------------
module clex_ident_ram (
    input  logic                               aclk,
    input  clex_pkg::ram_wr_t                  wr,
    input  clex_pkg::ram_rd_t                  rd,
    output logic [clex_pkg::VALUE_W-1:0]       rdata
);

    logic [clex_pkg::VALUE_W-1:0] mem [clex_pkg::NUM_ROWS];
    logic [clex_pkg::VALUE_W-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (wr.en) begin
            mem[wr.addr[clex_pkg::COUNT_W-1 -: clex_pkg::ROW_W]]
               [wr.addr[clex_pkg::CHUNK_SHIFT-1:0] * 8 +: 8] <= wr.data;
        end
    end

    // read data holds until the next read
    always_ff @(posedge aclk) begin
        if (rd.en) begin
            rdata_reg <= mem[rd.row];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ rtl/clex_scanner.sv @@
// ----------------------------------------------------------------------------
// clex_scanner
// token scanner: scan mode, integer accumulator, lookahead and chunk sequencer
// ----------------------------------------------------------------------------
module clex_scanner (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         in_valid,
    input  logic [7:0]                   in_byte,
    input  logic                         in_end,
    output logic                         in_take,
    input  logic                         out_free,
    output logic                         res_valid,
    output clex_pkg::token_t             res,
    output clex_pkg::ram_wr_t            ram_wr,
    output clex_pkg::ram_rd_t            ram_rd,
    input  logic [clex_pkg::VALUE_W-1:0] ram_rdata
);

    localparam logic [7:0] CH_UNDER = 8'h5F;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    typedef enum logic [3:0] {
        MODE_IDLE  = 4'b0001,
        MODE_IDENT = 4'b0010,
        MODE_INT   = 4'b0100,
        MODE_OP    = 4'b1000
    } scan_mode_t;

    typedef enum logic [2:0] {
        SEQ_RUN   = 3'b001,
        SEQ_CHUNK = 3'b010,
        SEQ_END   = 3'b100
    } seq_state_t;

    typedef struct packed {
        logic                        hit;
        logic [clex_pkg::KIND_W-1:0] kind;
    } op_match_t;

    function automatic logic is_alpha(input logic [7:0] c);
        return (c inside {[8'h61:8'h7A], [8'h41:8'h5A]}) || (c == CH_UNDER);
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return c inside {[CH_ZERO:CH_NINE]};
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return c inside {8'h20, 8'h0A, 8'h09, 8'h0D};
    endfunction

    function automatic op_match_t match_op(input logic [7:0] a, input logic [7:0] b);
        op_match_t m;
        m.hit  = 1'b1;
        m.kind = clex_pkg::KIND_IDENT;
        case ({a, b})
            {8'h2D, 8'h3E}: m.kind = clex_pkg::KIND_ARROW;
            {8'h3D, 8'h3D}: m.kind = clex_pkg::KIND_EQ;
            {8'h3E, 8'h3E}: m.kind = clex_pkg::KIND_SHR;
            {8'h3C, 8'h3C}: m.kind = clex_pkg::KIND_SHL;
            {8'h21, 8'h3D}: m.kind = clex_pkg::KIND_NE;
            {8'h3E, 8'h3D}: m.kind = clex_pkg::KIND_GE;
            {8'h3C, 8'h3D}: m.kind = clex_pkg::KIND_LE;
            {8'h7C, 8'h7C}: m.kind = clex_pkg::KIND_OR;
            {8'h26, 8'h26}: m.kind = clex_pkg::KIND_AND;
            default:        m.hit  = 1'b0;
        endcase
        return m;
    endfunction

    seq_state_t                    seq_reg, seq_next;
    scan_mode_t                    mode_reg, mode_next;
    logic [clex_pkg::COUNT_W-1:0]  count_reg, count_next;
    logic [clex_pkg::VALUE_W-1:0]  acc_reg, acc_next;
    logic [7:0]                    pend_reg, pend_next;
    logic [clex_pkg::COUNT_W-1:0]  flen_reg, flen_next;
    logic                          fflag_reg, fflag_next;
    logic [clex_pkg::ROW_W-1:0]    chunk_reg, chunk_next;
    logic                          restart_pend_reg, restart_pend_next;
    logic [7:0]                    restart_byte_reg, restart_byte_next;
    logic                          end_pend_reg, end_pend_next;

    logic                          start_en;
    logic [7:0]                    start_byte;
    logic                          in_alnum;
    op_match_t                     op_m;
    logic [clex_pkg::COUNT_W-1:0]  flen_m1;
    logic                          last_chunk;
    logic [clex_pkg::VALUE_W-1:0]  chunk_value;
    logic [clex_pkg::VALUE_W-1:0]  acc_step;

    assign in_alnum   = is_alpha(in_byte) || is_digit(in_byte);
    assign op_m       = match_op(pend_reg, in_byte);
    assign flen_m1    = flen_reg - clex_pkg::COUNT_W'(1);
    assign last_chunk = (chunk_reg == flen_m1[clex_pkg::COUNT_W-1 -: clex_pkg::ROW_W]);
    assign acc_step   = (acc_reg << 3) + (acc_reg << 1)
                      + clex_pkg::VALUE_W'(in_byte - CH_ZERO);

    // bytes past the identifier length read as zero
    always_comb begin
        logic [clex_pkg::COUNT_W-1:0] lane_idx;
        lane_idx    = '0;
        chunk_value = '0;
        for (int i = 0; i < clex_pkg::CHUNK_BYTES; i++) begin
            lane_idx = {chunk_reg, clex_pkg::CHUNK_SHIFT'(i)};
            if (lane_idx < flen_reg) begin
                chunk_value[i*8 +: 8] = ram_rdata[i*8 +: 8];
            end
        end
    end

    always_comb begin
        seq_next          = seq_reg;
        mode_next         = mode_reg;
        count_next        = count_reg;
        acc_next          = acc_reg;
        pend_next         = pend_reg;
        flen_next         = flen_reg;
        fflag_next        = fflag_reg;
        chunk_next        = chunk_reg;
        restart_pend_next = restart_pend_reg;
        restart_byte_next = restart_byte_reg;
        end_pend_next     = end_pend_reg;
        in_take           = 1'b0;
        res_valid         = 1'b0;
        res               = '0;
        ram_wr            = '0;
        ram_rd            = '0;
        start_en          = 1'b0;
        start_byte        = in_byte;

        case (seq_reg)
            SEQ_RUN: begin
                if (in_valid) begin
                    if (in_end) begin
                        case (mode_reg)
                            MODE_IDENT: begin
                                in_take           = 1'b1;
                                flen_next         = count_reg;
                                fflag_next        = 1'b0;
                                restart_pend_next = 1'b0;
                                end_pend_next     = 1'b1;
                                chunk_next        = '0;
                                ram_rd.en         = 1'b1;
                                mode_next         = MODE_IDLE;
                                count_next        = '0;
                                seq_next          = SEQ_CHUNK;
                            end
                            MODE_INT, MODE_OP: begin
                                if (out_free) begin
                                    in_take   = 1'b1;
                                    res_valid = 1'b1;
                                    if (mode_reg == MODE_INT) begin
                                        res.kind  = clex_pkg::KIND_INT;
                                        res.value = acc_reg;
                                    end else begin
                                        res.kind  = clex_pkg::KIND_PUNCT;
                                        res.value = clex_pkg::VALUE_W'(pend_reg);
                                    end
                                    mode_next = MODE_IDLE;
                                    seq_next  = SEQ_END;
                                end
                            end
                            default: begin
                                if (out_free) begin
                                    in_take   = 1'b1;
                                    res_valid = 1'b1;
                                    res.kind  = clex_pkg::KIND_END;
                                    res.last  = 1'b1;
                                    mode_next = MODE_IDLE;
                                end
                            end
                        endcase
                    end else begin
                        case (mode_reg)
                            MODE_IDENT: begin
                                in_take = 1'b1;
                                if (in_alnum
                                    && (count_reg < clex_pkg::COUNT_W'(clex_pkg::MAX_IDENT)))
                                begin
                                    ram_wr.en   = 1'b1;
                                    ram_wr.addr = count_reg;
                                    ram_wr.data = in_byte;
                                    count_next  = count_reg + clex_pkg::COUNT_W'(1);
                                end else begin
                                    // identifier ends: flagged when overlong, the byte restarts later
                                    flen_next         = count_reg;
                                    fflag_next        = in_alnum;
                                    restart_pend_next = 1'b1;
                                    restart_byte_next = in_byte;
                                    end_pend_next     = 1'b0;
                                    chunk_next        = '0;
                                    ram_rd.en         = 1'b1;
                                    mode_next         = MODE_IDLE;
                                    count_next        = '0;
                                    seq_next          = SEQ_CHUNK;
                                end
                            end
                            MODE_INT: begin
                                if (is_digit(in_byte)) begin
                                    in_take  = 1'b1;
                                    acc_next = acc_step;
                                end else if (in_byte == CH_UNDER) begin
                                    in_take = 1'b1;
                                end else if (out_free) begin
                                    in_take   = 1'b1;
                                    res_valid = 1'b1;
                                    res.kind  = clex_pkg::KIND_INT;
                                    res.value = acc_reg;
                                    res.last  = 1'b1;
                                    acc_next  = '0;
                                    start_en  = 1'b1;
                                end
                            end
                            MODE_OP: begin
                                if (out_free) begin
                                    in_take   = 1'b1;
                                    res_valid = 1'b1;
                                    res.last  = 1'b1;
                                    if (op_m.hit) begin
                                        res.kind  = op_m.kind;
                                        mode_next = MODE_IDLE;
                                    end else begin
                                        res.kind  = clex_pkg::KIND_PUNCT;
                                        res.value = clex_pkg::VALUE_W'(pend_reg);
                                        start_en  = 1'b1;
                                    end
                                end
                            end
                            default: begin
                                in_take  = 1'b1;
                                start_en = 1'b1;
                            end
                        endcase
                    end
                end
            end
            SEQ_CHUNK: begin
                if (out_free) begin
                    res_valid = 1'b1;
                    res.kind  = clex_pkg::KIND_IDENT;
                    res.value = chunk_value;
                    res.len   = flen_reg;
                    res.chunk = chunk_reg;
                    res.flag  = fflag_reg;
                    res.last  = last_chunk && !end_pend_reg;
                    if (!last_chunk) begin
                        chunk_next = chunk_reg + clex_pkg::ROW_W'(1);
                        ram_rd.en  = 1'b1;
                        ram_rd.row = chunk_reg + clex_pkg::ROW_W'(1);
                    end else begin
                        seq_next          = end_pend_reg ? SEQ_END : SEQ_RUN;
                        restart_pend_next = 1'b0;
                        end_pend_next     = 1'b0;
                        if (restart_pend_reg) begin
                            start_en   = 1'b1;
                            start_byte = restart_byte_reg;
                        end
                    end
                end
            end
            SEQ_END: begin
                if (out_free) begin
                    res_valid = 1'b1;
                    res.kind  = clex_pkg::KIND_END;
                    res.last  = 1'b1;
                    seq_next  = SEQ_RUN;
                end
            end
            default: begin
                seq_next = SEQ_RUN;
            end
        endcase

        // begin a new token on a byte seen in idle, on a byte that closed a token, or on the held restart byte
        if (start_en) begin
            mode_next = MODE_IDLE;
            if (is_alpha(start_byte)) begin
                ram_wr.en   = 1'b1;
                ram_wr.addr = '0;
                ram_wr.data = start_byte;
                count_next  = clex_pkg::COUNT_W'(1);
                mode_next   = MODE_IDENT;
            end else if (is_digit(start_byte)) begin
                acc_next  = clex_pkg::VALUE_W'(start_byte - CH_ZERO);
                mode_next = MODE_INT;
            end else if (!is_space(start_byte)) begin
                pend_next = start_byte;
                mode_next = MODE_OP;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seq_reg          <= SEQ_RUN;
            mode_reg         <= MODE_IDLE;
            count_reg        <= '0;
            acc_reg          <= '0;
            pend_reg         <= '0;
            restart_pend_reg <= 1'b0;
            end_pend_reg     <= 1'b0;
        end else begin
            seq_reg          <= seq_next;
            mode_reg         <= mode_next;
            count_reg        <= count_next;
            acc_reg          <= acc_next;
            pend_reg         <= pend_next;
            restart_pend_reg <= restart_pend_next;
            end_pend_reg     <= end_pend_next;
        end
    end

    always_ff @(posedge aclk) begin
        flen_reg         <= flen_next;
        fflag_reg        <= fflag_next;
        chunk_reg        <= chunk_next;
        restart_byte_reg <= restart_byte_next;
    end

endmodule

@@ rtl/clex_out_reg.sv @@
// ----------------------------------------------------------------------------
// clex_out_reg
// registered result stage driving the master stream
// ----------------------------------------------------------------------------
module clex_out_reg (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         load,
    input  clex_pkg::token_t             tok,
    output logic                         free,
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [clex_pkg::TDATA_W-1:0] m_tdata,
    output logic [clex_pkg::TUSER_W-1:0] m_tuser,
    output logic                         m_tlast
);

    clex_pkg::token_t tok_reg;
    logic             valid_reg, valid_next;

    assign free = !valid_reg || m_tready;

    always_comb begin
        valid_next = valid_reg;
        if (load) begin
            valid_next = 1'b1;
        end else if (m_tready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            tok_reg <= tok;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = {1'b0, tok_reg.chunk, tok_reg.len, tok_reg.value};
    assign m_tuser  = {tok_reg.flag, tok_reg.kind};
    assign m_tlast  = tok_reg.last;

endmodule

@@ rtl/c_like_token_lexer_core.sv @@
// ----------------------------------------------------------------------------
// c_like_token_lexer_core
// streaming lexer for c-like source text, one byte per transaction
// ----------------------------------------------------------------------------
// Takes source bytes on the slave stream and returns tokens on the master
// stream: identifiers (sent as one transaction per 8-byte chunk), decimal
// integers with '_' separators that wrap at 64 bits, nine two-character
// operators found with one byte of lookahead, single punctuation bytes and an
// end token after each end marker. Whitespace is skipped. Bytes that continue
// or begin a token, and bytes that close an integer or an operator lookahead,
// go through at one per cycle, a closing byte only while the output register
// can take its result. A byte or end marker that closes an identifier holds
// back later bytes while its chunks and any end token are sent: the identifier
// buffer is a single memory read one 8-byte row per cycle through a registered
// read port, and every token leaves through one output register. An end marker
// that flushes an integer or a pending lookahead sends the flushed token, then
// the end token. A one-entry input register lets a byte be taken while a
// result still waits at the output. No clearing pass is needed after reset.
// ----------------------------------------------------------------------------
module c_like_token_lexer_core (
    input  logic                         aclk,
    input  logic                         aresetn,
    // slave stream: source bytes
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [7:0]                   s_tdata,   // [7:0] source_byte
    input  logic                         s_tuser,   // [0] end_of_input
    // master stream: tokens
    output logic                         m_tvalid,
    input  logic                         m_tready,
    // [63:0] token_value, [68:64] ident_length, [70:69] chunk_index, [71] zero
    output logic [clex_pkg::TDATA_W-1:0] m_tdata,
    // [3:0] token_kind, [4] too_long_flag
    output logic [clex_pkg::TUSER_W-1:0] m_tuser,
    output logic                         m_tlast    // last_of_run
);

    // input holding register
    logic       in_valid_reg, in_valid_next;
    logic [7:0] in_byte_reg;
    logic       in_end_reg;
    logic       in_take;

    // scanner to output stage
    logic                         res_valid;
    clex_pkg::token_t             res;
    logic                         out_free;

    // identifier buffer ports
    clex_pkg::ram_wr_t            ram_wr;
    clex_pkg::ram_rd_t            ram_rd;
    logic [clex_pkg::VALUE_W-1:0] ram_rdata;

    // a new transaction lands when the register is empty or being drained
    assign s_tready = !in_valid_reg || in_take;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_tvalid && s_tready) begin
            in_valid_next = 1'b1;
        end else if (in_take) begin
            in_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_byte_reg <= s_tdata;
            in_end_reg  <= s_tuser;
        end
    end

    // scan mode, accumulator, lookahead and identifier chunk sequencing
    clex_scanner u_scanner (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (in_valid_reg),
        .in_byte   (in_byte_reg),
        .in_end    (in_end_reg),
        .in_take   (in_take),
        .out_free  (out_free),
        .res_valid (res_valid),
        .res       (res),
        .ram_wr    (ram_wr),
        .ram_rd    (ram_rd),
        .ram_rdata (ram_rdata)
    );

    // identifier characters, 8 per row
    clex_ident_ram u_ident_ram (
        .aclk  (aclk),
        .wr    (ram_wr),
        .rd    (ram_rd),
        .rdata (ram_rdata)
    );

    // result register on the master side
    clex_out_reg u_out_reg (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (res_valid),
        .tok      (res),
        .free     (out_free),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule
